/* hw/rtl/fdtd_pkg.sv */
// ============================================================================
// fdtd_pkg
// Shared types, constants and fixed-point helpers for the 1-D FDTD field
// update block.
// ============================================================================
package fdtd_pkg;

    localparam int FIELD_W    = 24;   // Q3.20 field sample
    localparam int GAIN_W     = 18;   // unsigned Q2.16 gain
    localparam int CELL_W     = 8;    // width of the cell index registers
    localparam int PROD_W     = 44;   // difference times gain
    localparam int DELTA_W    = 28;   // rounded product
    localparam int SUM_W      = 29;   // field plus rounded product
    localparam int CFG_IDX_W  = 2;
    localparam int ROUND_SH   = 16;
    localparam int ROUND_HALF = 32768;
    localparam int CELLS_DEF  = 256;

    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [DELTA_W-1:0] t_delta;

    localparam t_field FIELD_MAX = 24'sh7FFFFF;
    localparam t_field FIELD_MIN = 24'sh800000;

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 18'h10000;
    localparam logic [CELL_W-1:0] SOURCE_RESET = 8'd100;
    localparam logic [CELL_W-1:0] PROBE_RESET  = 8'd50;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H_GAIN = 2'd0,
        CFG_E_GAIN = 2'd1,
        CFG_SOURCE = 2'd2,
        CFG_PROBE  = 2'd3
    } t_cfg_idx;

    // read issue tag, travels alongside the memory read data
    typedef struct packed {
        logic vld;
        logic first;
    } t_iss;

    // flags of one finished electric cell
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic sat;
    } t_cell;

    // result stage status
    typedef struct packed {
        logic pend;
        logic loaded;
    } t_sts;

    typedef struct packed {
        logic   sat;
        t_field val;
    } t_sat;

    // floor((p + 2^15) / 2^16)
    function automatic t_delta f_round(input t_prod p);
        t_prod q;
        q = p + PROD_W'(ROUND_HALF);
        return q[PROD_W-1:ROUND_SH];
    endfunction

    // saturating field update
    function automatic t_sat f_sat_add(input t_field base, input t_delta delta);
        logic signed [SUM_W-1:0] s;
        t_sat r;
        s = SUM_W'(base) + SUM_W'(delta);
        if (s > SUM_W'(FIELD_MAX)) begin
            r.sat = 1'b1;
            r.val = FIELD_MAX;
        end else if (s < SUM_W'(FIELD_MIN)) begin
            r.sat = 1'b1;
            r.val = FIELD_MIN;
        end else begin
            r.sat = 1'b0;
            r.val = s[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/fdtd_ram.sv */
// ============================================================================
// fdtd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module fdtd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/fdtd_cell_pipe.sv */
// ============================================================================
// fdtd_cell_pipe
// Fused cell pipeline: takes old E and H of consecutive cells from the
// memories, computes the new H of cell m, then the new E of cell m from
// the new H of cells m and m-1, applies the hard source, and hands back the
// write data for both memories.
// ============================================================================
module fdtd_cell_pipe
    import fdtd_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_iss                     i_iss,
    input  t_field                   i_e_rdata,
    input  t_field                   i_h_rdata,
    input  logic [GAIN_W-1:0]        i_h_gain,
    input  logic [GAIN_W-1:0]        i_e_gain,
    input  logic [CELL_W-1:0]        i_source_cell,
    input  t_field                   i_sample,
    output logic                     o_h_we,
    output logic [$clog2(CELLS)-1:0] o_h_waddr,
    output t_field                   o_h_wdata,
    output t_cell                    o_cell,
    output logic [$clog2(CELLS)-1:0] o_cell_idx,
    output t_field                   o_cell_val
);

    localparam int AW = $clog2(CELLS);
    localparam int CW = (AW > CELL_W) ? AW : CELL_W;

    // previous read word: old E and H of the cell now entering stage A
    t_field r_e_prev;
    t_field r_h_prev;
    logic [AW-1:0] r_cnt;

    // stage A: H product registered
    logic          r_a_vld;
    logic [AW-1:0] r_a_idx;
    t_field        r_a_e;
    t_field        r_a_h;
    t_prod         r_a_prod;

    // stage B: new H
    logic          r_b_vld;
    logic [AW-1:0] r_b_idx;
    t_field        r_b_e;
    t_field        r_b_hn;
    logic          r_b_sat;
    t_field        r_hprev;

    // stage C: E product registered
    logic          r_c_vld;
    logic [AW-1:0] r_c_idx;
    t_field        r_c_e;
    t_prod         r_c_prod;
    logic          r_c_sat;

    // stage D: new E
    t_cell         r_d;
    logic [AW-1:0] r_d_idx;
    t_field        r_d_val;

    logic signed [FIELD_W:0] w_dh;
    logic signed [GAIN_W:0]  w_hg;
    t_prod                   w_hp;
    t_sat                    w_hsum;
    logic signed [FIELD_W:0] w_dhn;
    logic signed [GAIN_W:0]  w_eg;
    t_prod                   w_ep;
    t_sat                    w_esum;
    logic                    w_a_in;
    logic                    w_c_first;
    logic                    w_c_src;
    t_field                  w_e_new;
    logic                    w_e_sat;

    // H update: e[m+1] arrives from memory, e[m] is the previous word
    assign w_a_in = i_iss.vld && !i_iss.first;
    assign w_dh   = (FIELD_W+1)'(i_e_rdata) - (FIELD_W+1)'(r_e_prev);
    assign w_hg   = {1'b0, i_h_gain};
    assign w_hp   = w_dh * w_hg;
    assign w_hsum = f_sat_add(r_a_h, f_round(r_a_prod));

    // E update from new H of this cell and the one before
    assign w_dhn  = (FIELD_W+1)'(r_b_hn) - (FIELD_W+1)'(r_hprev);
    assign w_eg   = {1'b0, i_e_gain};
    assign w_ep   = w_dhn * w_eg;
    assign w_esum = f_sat_add(r_c_e, f_round(r_c_prod));

    // cell zero keeps its E; the source cell takes the sample
    assign w_c_first = (r_c_idx == '0);
    assign w_c_src   = (CW'(r_c_idx) == CW'(i_source_cell));
    always_comb begin
        w_e_new = w_c_first ? r_c_e : w_esum.val;
        w_e_sat = w_c_first ? 1'b0 : w_esum.sat;
        if (w_c_src) begin
            w_e_new = i_sample;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d     <= '0;
        end else begin
            if (i_iss.vld && i_iss.first) begin
                r_cnt <= '0;
            end else if (w_a_in) begin
                r_cnt <= AW'(r_cnt + 1'b1);
            end
            r_a_vld   <= w_a_in;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d.vld   <= r_c_vld;
            r_d.first <= w_c_first;
            r_d.last  <= (r_c_idx == AW'(CELLS-1));
            r_d.sat   <= r_c_sat | w_e_sat;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_iss.vld) begin
            r_e_prev <= i_e_rdata;
            r_h_prev <= i_h_rdata;
        end
        r_a_idx  <= r_cnt;
        r_a_e    <= r_e_prev;
        r_a_h    <= r_h_prev;
        r_a_prod <= (r_cnt == AW'(CELLS-1)) ? '0 : w_hp;

        r_b_idx <= r_a_idx;
        r_b_e   <= r_a_e;
        r_b_hn  <= w_hsum.val;
        r_b_sat <= w_hsum.sat;
        if (r_b_vld) begin
            r_hprev <= r_b_hn;
        end

        r_c_idx  <= r_b_idx;
        r_c_e    <= r_b_e;
        r_c_prod <= w_ep;
        r_c_sat  <= r_b_sat;

        r_d_idx <= r_c_idx;
        r_d_val <= w_e_new;
    end

    assign o_h_we     = r_b_vld;
    assign o_h_waddr  = r_b_idx;
    assign o_h_wdata  = r_b_hn;
    assign o_cell     = r_d;
    assign o_cell_idx = r_d_idx;
    assign o_cell_val = r_d_val;

endmodule

/* hw/rtl/fdtd_stats.sv */
// ============================================================================
// fdtd_stats
// Collects probe value, min, max and the saturation flag as finished
// electric cells stream by, and holds the result word for the output
// channel.
// ============================================================================
module fdtd_stats
    import fdtd_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell                    i_cell,
    input  logic [$clog2(CELLS)-1:0] i_cell_idx,
    input  t_field                   i_cell_val,
    input  logic [CELL_W-1:0]        i_probe_cell,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output t_field                   o_probe_value,
    output t_field                   o_field_min,
    output t_field                   o_field_max,
    output logic                     o_saturated,
    output t_sts                     o_sts
);

    localparam int AW = $clog2(CELLS);
    localparam int CW = (AW > CELL_W) ? AW : CELL_W;

    logic   r_pend;
    logic   r_out_vld;
    t_field r_probe;
    t_field r_lo;
    t_field r_hi;
    logic   r_sat;
    t_field r_out_probe;
    t_field r_out_lo;
    t_field r_out_hi;
    logic   r_out_sat;

    logic w_hit;
    logic w_load;

    assign w_hit  = (CW'(i_cell_idx) == CW'(i_probe_cell));
    assign w_load = r_pend && (!r_out_vld || i_out_ready);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_pend <= 1'b0;
            end else if (i_cell.vld && i_cell.last) begin
                r_pend <= 1'b1;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // running statistics over one sweep
    always_ff @(posedge i_clk) begin
        if (i_cell.vld) begin
            if (i_cell.first) begin
                r_sat   <= i_cell.sat;
                r_probe <= w_hit ? i_cell_val : '0;
            end else begin
                r_sat <= r_sat | i_cell.sat;
                if (w_hit) begin
                    r_probe <= i_cell_val;
                end
                if (i_cell_idx == AW'(1)) begin
                    r_lo <= i_cell_val;
                    r_hi <= i_cell_val;
                end else begin
                    if (i_cell_val < r_lo) begin
                        r_lo <= i_cell_val;
                    end
                    if (i_cell_val > r_hi) begin
                        r_hi <= i_cell_val;
                    end
                end
            end
        end
        if (w_load) begin
            r_out_probe <= r_probe;
            r_out_lo    <= r_lo;
            r_out_hi    <= r_hi;
            r_out_sat   <= r_sat;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_probe_value = r_out_probe;
    assign o_field_min   = r_out_lo;
    assign o_field_max   = r_out_hi;
    assign o_saturated   = r_out_sat;
    assign o_sts.pend    = r_pend;
    assign o_sts.loaded  = w_load;

endmodule

/* hw/rtl/fdtd_1d_field_update.sv */
// ============================================================================
// fdtd_1d_field_update
// One-dimensional Yee field update with a hard source. Each input word is one
// time step carrying the source sample; the block sweeps all CELLS cells once,
// updating H of a cell and then E of the same cell in a pipeline of stages A
// to D that moves one cell per clock, with one read and one write per field
// memory per cycle. The next step is accepted only once the previous result
// word has been loaded into the output register. After reset a clearing pass
// zeroes both field memories, during which no word is accepted; configuration
// writes are taken at any time the block is idle.
// ============================================================================
module fdtd_1d_field_update
    import fdtd_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_field               i_source_sample,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_field               o_probe_value,
    output t_field               o_field_min,
    output t_field               o_field_max,
    output logic                 o_saturated
);

    localparam int AW = $clog2(CELLS);
    localparam int KW = $clog2(CELLS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [KW-1:0]     r_k, n_k;
    t_iss              r_iss;
    logic [GAIN_W-1:0] r_h_gain;
    logic [GAIN_W-1:0] r_e_gain;
    logic [CELL_W-1:0] r_source;
    logic [CELL_W-1:0] r_probe;
    t_field            r_sample;

    logic          w_clr;
    logic [AW-1:0] w_rd_addr;
    t_field        w_e_rdata;
    t_field        w_h_rdata;
    logic          w_p_h_we;
    logic [AW-1:0] w_p_h_waddr;
    t_field        w_p_h_wdata;
    t_cell         w_cell;
    logic [AW-1:0] w_cell_idx;
    t_field        w_cell_val;
    t_sts          w_sts;
    logic          w_h_we;
    logic [AW-1:0] w_h_waddr;
    t_field        w_h_wdata;
    logic          w_e_we;
    logic [AW-1:0] w_e_waddr;
    t_field        w_e_wdata;
    logic          w_accept;

    assign w_clr      = (r_state == ST_CLEAR);
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // sequencer: clearing pass, then one sweep per accepted word
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_k == KW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                    n_k     = '0;
                end else begin
                    n_k = KW'(r_k + 1'b1);
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SWEEP;
                    n_k     = '0;
                end
            end
            ST_SWEEP: begin
                if (r_k == KW'(CELLS)) begin
                    n_state = ST_DRAIN;
                    n_k     = '0;
                end else begin
                    n_k = KW'(r_k + 1'b1);
                end
            end
            ST_DRAIN: begin
                if (w_sts.loaded) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_k     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
            r_iss   <= '0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_iss.vld <= (r_state == ST_SWEEP);
            r_iss.first <= (r_k == '0);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_gain <= GAIN_RESET;
            r_e_gain <= GAIN_RESET;
            r_source <= SOURCE_RESET;
            r_probe  <= PROBE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_H_GAIN: r_h_gain <= i_cfg_data;
                CFG_E_GAIN: r_e_gain <= i_cfg_data;
                CFG_SOURCE: r_source <= i_cfg_data[CELL_W-1:0];
                CFG_PROBE:  r_probe  <= i_cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // source sample of the step in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_source_sample;
        end
    end

    // memory ports; the clearing pass owns the write ports after reset
    assign w_rd_addr = (r_k < KW'(CELLS)) ? r_k[AW-1:0] : '0;
    assign w_h_we    = w_clr | w_p_h_we;
    assign w_h_waddr = w_clr ? r_k[AW-1:0] : w_p_h_waddr;
    assign w_h_wdata = w_clr ? '0 : w_p_h_wdata;
    assign w_e_we    = w_clr | w_cell.vld;
    assign w_e_waddr = w_clr ? r_k[AW-1:0] : w_cell_idx;
    assign w_e_wdata = w_clr ? '0 : w_cell_val;

    fdtd_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (CELLS)
    ) u_e_ram (
        .i_clk   (i_clk),
        .i_we    (w_e_we),
        .i_waddr (w_e_waddr),
        .i_wdata (w_e_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_e_rdata)
    );

    fdtd_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (CELLS)
    ) u_h_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (w_h_waddr),
        .i_wdata (w_h_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_h_rdata)
    );

    fdtd_cell_pipe #(
        .CELLS (CELLS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_iss         (r_iss),
        .i_e_rdata     (w_e_rdata),
        .i_h_rdata     (w_h_rdata),
        .i_h_gain      (r_h_gain),
        .i_e_gain      (r_e_gain),
        .i_source_cell (r_source),
        .i_sample      (r_sample),
        .o_h_we        (w_p_h_we),
        .o_h_waddr     (w_p_h_waddr),
        .o_h_wdata     (w_p_h_wdata),
        .o_cell        (w_cell),
        .o_cell_idx    (w_cell_idx),
        .o_cell_val    (w_cell_val)
    );

    fdtd_stats #(
        .CELLS (CELLS)
    ) u_stats (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell        (w_cell),
        .i_cell_idx    (w_cell_idx),
        .i_cell_val    (w_cell_val),
        .i_probe_cell  (r_probe),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_probe_value (o_probe_value),
        .o_field_min   (o_field_min),
        .o_field_max   (o_field_max),
        .o_saturated   (o_saturated),
        .o_sts         (w_sts)
    );

    // E write-back never lands on the cell being read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && w_e_we) |-> (w_e_waddr != w_rd_addr))
        else $error("E write-back hits the cell being read");

    // an accepted word starts a sweep from cell zero
    a_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SWEEP && r_k == '0))
        else $error("accepted word did not start a sweep");

    // no unfinished result is left behind when the block goes idle
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_sts.pend)
        else $error("result still pending while idle");

    // results are moved to the output register only at the end of a sweep
    a_load_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.loaded |-> (r_state == ST_DRAIN))
        else $error("result loaded outside the drain phase");

endmodule

/* bench/fdtd_step_monitor.sv */
`timescale 1ns / 1ps
// ============================================================================
// fdtd_step_monitor
// Watches the configuration port and both word channels of the 1-D field
// update block. It keeps its own copy of both field arrays and the four
// registers, advances them one time step per accepted input word, and checks
// each result word field by field against the oldest outstanding step.
// ============================================================================
module fdtd_step_monitor
    import fdtd_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_field               i_source_sample,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_field               i_probe_value,
    input  t_field               i_field_min,
    input  t_field               i_field_max,
    input  logic                 i_saturated,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        t_field probe;
        t_field lo;
        t_field hi;
        logic   sat;
    } t_step_result;

    // field arrays and register copies
    t_field            e_cell [CELLS];
    t_field            h_cell [CELLS];
    logic [GAIN_W-1:0] h_gain;
    logic [GAIN_W-1:0] e_gain;
    logic [CELL_W-1:0] src_cell;
    logic [CELL_W-1:0] probe_cell;

    t_step_result results_due[$];
    int           mismatches = 0;
    int           steps_due  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = steps_due;

    // floor((diff * gain + half) / 2^16)
    function automatic longint gain_scale(input longint diff, input logic [GAIN_W-1:0] gain);
        longint p;
        p = diff * longint'(gain) + 64'sd32768;
        return p >>> ROUND_SH;
    endfunction

    // cell update clamped to the Q3.20 range, flags any clamp
    function automatic t_field clamp_add(input t_field base, input longint delta,
                                         inout logic sat);
        longint s;
        s = longint'(base) + delta;
        if (s > longint'(FIELD_MAX)) begin
            sat = 1'b1;
            return FIELD_MAX;
        end
        if (s < longint'(FIELD_MIN)) begin
            sat = 1'b1;
            return FIELD_MIN;
        end
        return t_field'(s);
    endfunction

    // one time step: H sweep, E sweep, hard source, then probe and extremes
    task automatic yee_step(input t_field sample, output t_step_result r);
        logic   sat;
        t_field lo;
        t_field hi;
        sat = 1'b0;
        for (int m = 0; m + 1 < CELLS; m++)
            h_cell[m] = clamp_add(h_cell[m],
                gain_scale(longint'(e_cell[m+1]) - longint'(e_cell[m]), h_gain), sat);
        for (int m = 1; m < CELLS; m++)
            e_cell[m] = clamp_add(e_cell[m],
                gain_scale(longint'(h_cell[m]) - longint'(h_cell[m-1]), e_gain), sat);
        if (int'(src_cell) < CELLS)
            e_cell[src_cell] = sample;
        lo = e_cell[1];
        hi = e_cell[1];
        for (int m = 2; m < CELLS; m++) begin
            if (e_cell[m] < lo) lo = e_cell[m];
            if (e_cell[m] > hi) hi = e_cell[m];
        end
        r.probe = (int'(probe_cell) < CELLS) ? e_cell[probe_cell] : '0;
        r.lo    = lo;
        r.hi    = hi;
        r.sat   = sat;
    endtask

    task automatic check_field(input string name, input t_field want, input t_field got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        t_step_result want;
        if (!i_rst_n) begin
            foreach (e_cell[m]) begin
                e_cell[m] = '0;
                h_cell[m] = '0;
            end
            h_gain     = GAIN_RESET;
            e_gain     = GAIN_RESET;
            src_cell   = SOURCE_RESET;
            probe_cell = PROBE_RESET;
            results_due.delete();
            steps_due <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_H_GAIN: h_gain     = i_cfg_data;
                    CFG_E_GAIN: e_gain     = i_cfg_data;
                    CFG_SOURCE: src_cell   = i_cfg_data[CELL_W-1:0];
                    CFG_PROBE:  probe_cell = i_cfg_data[CELL_W-1:0];
                    default: ;
                endcase
            end
            // result word first: it belongs to an earlier step
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with no step outstanding");
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("probe_value", want.probe, i_probe_value);
                    check_field("field_min", want.lo, i_field_min);
                    check_field("field_max", want.hi, i_field_max);
                    check_field("saturated", {23'd0, want.sat}, {23'd0, i_saturated});
                end
            end
            if (i_in_valid && i_in_ready) begin
                yee_step(i_source_sample, want);
                results_due.push_back(want);
            end
            steps_due <= results_due.size();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives time steps into the 1-D field update block: a directed part with
// sample extremes, gain extremes and edge cells, then random phases of
// Gaussian pulses and noise under random settings and random idling on both
// channels. The step monitor predicts and checks; this module gives the verdict.
// ============================================================================
module testbench;
    import fdtd_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int TAIL_ITEMS   = 40;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [GAIN_W-1:0]    i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    t_field               i_source_sample = '0;
    logic                 i_out_ready     = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_field               o_probe_value;
    t_field               o_field_min;
    t_field               o_field_max;
    logic                 o_saturated;
    int                   fail_count;
    int                   steps_pending;

    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int ready_hold    = 0;
    int random_sent   = 0;

    always #10 i_clk = ~i_clk;

    fdtd_1d_field_update dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_source_sample (i_source_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_probe_value   (o_probe_value),
        .o_field_min     (o_field_min),
        .o_field_max     (o_field_max),
        .o_saturated     (o_saturated)
    );

    fdtd_step_monitor u_step_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_source_sample (i_source_sample),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_probe_value   (o_probe_value),
        .i_field_min     (o_field_min),
        .i_field_max     (o_field_max),
        .i_saturated     (o_saturated),
        .o_fail_count    (fail_count),
        .o_pending       (steps_pending)
    );

    // result back-pressure: ready drops low in random bursts
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ready_hold - 1;
        end else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
            i_out_ready <= 1'b0;
            ready_hold  <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // writes the registers flagged in sel, one per cycle; block must be idle
    task automatic write_settings(input logic [GAIN_W-1:0] h_gain,
                                  input logic [GAIN_W-1:0] e_gain,
                                  input logic [GAIN_W-1:0] src_data,
                                  input logic [GAIN_W-1:0] probe_data,
                                  input logic [3:0]        sel);
        if (sel[CFG_H_GAIN]) begin
            i_cfg_we <= 1'b1; i_cfg_index <= CFG_H_GAIN; i_cfg_data <= h_gain;
            @(posedge i_clk);
        end
        if (sel[CFG_E_GAIN]) begin
            i_cfg_we <= 1'b1; i_cfg_index <= CFG_E_GAIN; i_cfg_data <= e_gain;
            @(posedge i_clk);
        end
        if (sel[CFG_SOURCE]) begin
            i_cfg_we <= 1'b1; i_cfg_index <= CFG_SOURCE; i_cfg_data <= src_data;
            @(posedge i_clk);
        end
        if (sel[CFG_PROBE]) begin
            i_cfg_we <= 1'b1; i_cfg_index <= CFG_PROBE; i_cfg_data <= probe_data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // one time step word; valid stays up into the next word unless a gap follows
    task automatic send_step(input t_field sample);
        int gap;
        i_in_valid      <= 1'b1;
        i_source_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid and wait until every result word is back
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (steps_pending != 0) @(posedge i_clk);
    endtask

    // Gaussian pulse of random height and width
    task automatic send_pulse(input int count);
        real    amp;
        real    width;
        real    d;
        t_field r;
        r     = t_field'($urandom);
        amp   = r;
        width = $urandom_range(1, 12);
        for (int t = 0; t < count; t++) begin
            d = (t - 3.0 * width) / width;
            send_step(t_field'($rtoi(amp * $exp(-(d * d)))));
        end
    endtask

    // random settings: mostly a stable Courant product, sometimes anything
    task automatic pick_settings();
        logic [GAIN_W-1:0] h_gain;
        logic [GAIN_W-1:0] e_gain;
        if ($urandom_range(0, 9) == 0) begin
            h_gain = GAIN_W'($urandom);
            e_gain = GAIN_W'($urandom);
        end else begin
            h_gain = GAIN_W'($urandom_range(16384, 65536));
            e_gain = GAIN_W'($urandom_range(16384, 65536));
        end
        write_settings(h_gain, e_gain, GAIN_W'($urandom), GAIN_W'($urandom),
                       4'($urandom_range(1, 15)));
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 15;
            2:       return 40;
            default: return 70;
        endcase
    endfunction

    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample extremes under reset settings
        in_gap_pct    = 30;
        out_stall_pct = 30;
        send_step(FIELD_MAX);
        send_step(FIELD_MIN);
        send_step('0);
        send_step(t_field'(-1));
        send_step(24'sh555555);
        send_step(24'shAAAAAA);
        send_step(24'sd1);
        finish_phase();

        // largest gains, source and probe at cell zero: saturation
        write_settings(18'h3FFFF, 18'h3FFFF, 18'h3FF00, 18'h00000, 4'hF);
        send_step(FIELD_MAX);
        send_step(FIELD_MIN);
        send_step(FIELD_MAX);
        send_step('0);
        finish_phase();

        // zero gains, last cell
        write_settings(18'h00000, 18'h00000, 18'd255, 18'd255, 4'hF);
        repeat (3) send_step(t_field'($urandom));
        finish_phase();

        // unit gains, first cell that counts toward the extremes
        write_settings(GAIN_RESET, GAIN_RESET, 18'd1, 18'd1, 4'hF);
        repeat (5) send_step(t_field'($urandom));
        finish_phase();

        // random phases
        while (random_sent < RANDOM_ITEMS - TAIL_ITEMS) begin
            pick_settings();
            in_gap_pct    = pick_idle_pct();
            out_stall_pct = pick_idle_pct();
            n = $urandom_range(10, 60);
            if ($urandom_range(0, 4) == 0) begin
                repeat (n) send_step(t_field'($urandom));
            end else begin
                send_pulse(n);
            end
            random_sent += n;
            finish_phase();
        end

        // last part without idling
        in_gap_pct    = 0;
        out_stall_pct = 0;
        pick_settings();
        send_pulse(TAIL_ITEMS);
        finish_phase();

        repeat (CELLS_DEF + 16) @(posedge i_clk);
        if (fail_count == 0 && steps_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fdtd_pkg.sv
hw/rtl/fdtd_ram.sv
hw/rtl/fdtd_cell_pipe.sv
hw/rtl/fdtd_stats.sv
hw/rtl/fdtd_1d_field_update.sv
bench/fdtd_step_monitor.sv
bench/testbench.sv
